@@ rtl/time_window_metric_totals_defines.svh @@
// Assertion macros used by the top level of the time window totals block.
`ifndef TIME_WINDOW_METRIC_TOTALS_DEFINES_SVH
`define TIME_WINDOW_METRIC_TOTALS_DEFINES_SVH

// Implication within the same clock edge, ignored while reset is held.
`define TWMT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked at the next clock edge, ignored while reset is held.
`define TWMT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/twmt_pkg.sv @@
// Package with the sizes, codes and shared types of the time window totals block.
package twmt_pkg;

  // Sample store depth and the widths that follow from it.
  localparam int DEPTH       = 256;
  localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W     = $clog2(DEPTH + 1);

  // Fixed field widths.
  localparam int NUM_METRICS = 8;
  localparam int METRIC_W    = 32;
  localparam int TOTAL_W     = 40;
  localparam int TIME_W      = 32;
  localparam int ENTRY_W     = 9;

  // Item command codes.
  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_EXPIRE = 1'b1;

  typedef logic [ADDR_W-1:0]                          addr_t;
  typedef logic [COUNT_W-1:0]                         count_t;
  typedef logic [NUM_METRICS-1:0][METRIC_W-1:0]       metrics_t;
  typedef logic [NUM_METRICS-1:0][TOTAL_W-1:0]        totals_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // register the input item
    logic add_phase;  // store and add the sample, or flag the drop
    logic rd_next;    // read the slot after the head instead of the head
    logic retire;     // subtract the head sample and advance the head
    logic load_out;   // load the result register
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic add_hits_head;  // an add writes the slot that the head read needs
    logic empty;          // no sample held
    logic expired;        // head sample is held and older than the window
  } stat_t;

endpackage

@@ rtl/time_window_metric_totals.sv @@
// Top level of the sliding time window totals block over eight traffic counters.
//
// Use: the input channel (in_valid, in_stall) transfers one item: an add (in_cmd 0)
// that stores a time-stamped sample of eight counters, or an expire-only item
// (in_cmd 1). Each item then retires every head sample whose time plus the
// window lies before in_now_time. The output channel (out_valid, out_stall)
// transfers one result per item: the eight totals, the entry count and the drop
// flag. The window register is written through cfg_wr_en and cfg_wr_data; the user
// must write it only while the block is idle, which the block itself does not enforce.
// Timing: one item is worked on at a time. After its transfer the item passes the add
// state, then a fetch state when an add lands in an empty store, then the check state,
// which retires one expired head sample each time round; its result is loaded into
// the output register once no expired sample is left. The fetch state is set by the
// registered read port of the sample store, which reads one head entry a cycle. The
// next item can be transferred in the cycle after the load. A finished result sits
// in the output register, and the next item is accepted while it waits; if the
// receiver stalls, the following result is held back and no further item is taken
// until the register frees. Reset: totals clear, the store is empty, the window is 1
// time unit; no clearing pass is needed, so the block is ready as soon as reset ends.
`include "time_window_metric_totals_defines.svh"

module time_window_metric_totals (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [twmt_pkg::TIME_W-1:0]        cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_cmd,
  input  logic [twmt_pkg::TIME_W-1:0]        in_sample_time,
  input  logic [twmt_pkg::TIME_W-1:0]        in_now_time,
  input  logic [twmt_pkg::METRIC_W-1:0]      in_dl_bytes,
  input  logic [twmt_pkg::METRIC_W-1:0]      in_ul_bytes,
  input  logic [twmt_pkg::METRIC_W-1:0]      in_dl_prbs,
  input  logic [twmt_pkg::METRIC_W-1:0]      in_ul_prbs,
  input  logic [twmt_pkg::METRIC_W-1:0]      in_tx_pkts,
  input  logic [twmt_pkg::METRIC_W-1:0]      in_tx_errors,
  input  logic [twmt_pkg::METRIC_W-1:0]      in_rx_pkts,
  input  logic [twmt_pkg::METRIC_W-1:0]      in_rx_errors,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [twmt_pkg::TOTAL_W-1:0]       out_sum_dl_bytes,
  output logic [twmt_pkg::TOTAL_W-1:0]       out_sum_ul_bytes,
  output logic [twmt_pkg::TOTAL_W-1:0]       out_sum_dl_prbs,
  output logic [twmt_pkg::TOTAL_W-1:0]       out_sum_ul_prbs,
  output logic [twmt_pkg::TOTAL_W-1:0]       out_sum_tx_pkts,
  output logic [twmt_pkg::TOTAL_W-1:0]       out_sum_tx_errors,
  output logic [twmt_pkg::TOTAL_W-1:0]       out_sum_rx_pkts,
  output logic [twmt_pkg::TOTAL_W-1:0]       out_sum_rx_errors,
  output logic [twmt_pkg::ENTRY_W-1:0]       out_entry_count,
  output logic                               out_dropped
);

  twmt_pkg::ctrl_t    cmd;
  twmt_pkg::stat_t    st;
  twmt_pkg::metrics_t in_metrics;
  twmt_pkg::totals_t  out_sums;

  // Gather the counters of the sample in a fixed lane order.
  assign in_metrics[0] = in_dl_bytes;
  assign in_metrics[1] = in_ul_bytes;
  assign in_metrics[2] = in_dl_prbs;
  assign in_metrics[3] = in_ul_prbs;
  assign in_metrics[4] = in_tx_pkts;
  assign in_metrics[5] = in_tx_errors;
  assign in_metrics[6] = in_rx_pkts;
  assign in_metrics[7] = in_rx_errors;

  // Controller.
  twmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // Datapath.
  twmt_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_cmd          (in_cmd),
    .in_sample_time  (in_sample_time),
    .in_now_time     (in_now_time),
    .in_metrics      (in_metrics),
    .out_sums        (out_sums),
    .out_entry_count (out_entry_count),
    .out_dropped     (out_dropped)
  );

  // Spread the totals back over the result ports.
  assign out_sum_dl_bytes  = out_sums[0];
  assign out_sum_ul_bytes  = out_sums[1];
  assign out_sum_dl_prbs   = out_sums[2];
  assign out_sum_ul_prbs   = out_sums[3];
  assign out_sum_tx_pkts   = out_sums[4];
  assign out_sum_tx_errors = out_sums[5];
  assign out_sum_rx_pkts   = out_sums[6];
  assign out_sum_rx_errors = out_sums[7];

  // An accepted transfer keeps the input side busy for the following cycle.
  `TWMT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "input accepted twice in a row")
  // A sample is never retired from an empty store.
  `TWMT_ASSERT_SAME(a_no_retire_empty, clk, rst_n, st.empty, !cmd.retire, "retire with empty store")
  // The result register is only loaded once the expiry pass has ended.
  `TWMT_ASSERT_SAME(a_load_after_expiry, clk, rst_n, cmd.load_out, !cmd.retire && !st.expired, "result loaded during expiry")
  // The reported entry count never exceeds the store depth.
  `TWMT_ASSERT_SAME(a_count_bound, clk, rst_n, out_valid, out_entry_count <= twmt_pkg::ENTRY_W'(twmt_pkg::DEPTH), "entry count beyond depth")

endmodule

@@ rtl/twmt_ctrl.sv @@
// Controller state machine that sequences add, expiry and result transfer.
module twmt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  twmt_pkg::stat_t st,
  output twmt_pkg::ctrl_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ADD   = 5'b00010,
    ST_FETCH = 5'b00100,
    ST_CHECK = 5'b01000,
    ST_WAIT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // The result register can take a new result when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.add_phase = 1'b1;
        state_nxt     = st.add_hits_head ? ST_FETCH : ST_CHECK;
      end
      ST_FETCH: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (st.expired) begin
          cmd.retire  = 1'b1;
          cmd.rd_next = 1'b1;
        end else if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result valid flag follows loads and completed transfers.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ rtl/twmt_dp.sv @@
// Datapath with the sample store, running totals, indexes and result register.
module twmt_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  twmt_pkg::ctrl_t                        cmd,
  output twmt_pkg::stat_t                        st,
  input  logic                                   cfg_wr_en,
  input  logic [twmt_pkg::TIME_W-1:0]            cfg_wr_data,
  input  logic                                   in_cmd,
  input  logic [twmt_pkg::TIME_W-1:0]            in_sample_time,
  input  logic [twmt_pkg::TIME_W-1:0]            in_now_time,
  input  twmt_pkg::metrics_t                     in_metrics,
  output twmt_pkg::totals_t                      out_sums,
  output logic [twmt_pkg::ENTRY_W-1:0]           out_entry_count,
  output logic                                   out_dropped
);

  // Configuration and captured item.
  logic [twmt_pkg::TIME_W-1:0] window_r;
  logic                        cmd_r;
  logic [twmt_pkg::TIME_W-1:0] stime_r;
  logic [twmt_pkg::TIME_W-1:0] now_r;
  twmt_pkg::metrics_t          metrics_r;

  // Queue control and totals.
  twmt_pkg::addr_t   head_r, head_nxt, tail_r, tail_nxt, head_inc, tail_inc, rd_addr;
  twmt_pkg::count_t  count_r, count_nxt;
  twmt_pkg::totals_t totals_r, totals_nxt;
  logic              drop_r, drop_nxt;
  logic              full, push;

  // Sample store and registered read data.
  logic [twmt_pkg::TIME_W-1:0] time_mem [twmt_pkg::DEPTH];
  twmt_pkg::metrics_t          metric_mem [twmt_pkg::DEPTH];
  logic [twmt_pkg::TIME_W-1:0] rd_time_r;
  twmt_pkg::metrics_t          rd_metrics_r;

  // Result register.
  twmt_pkg::totals_t           res_sums_r;
  logic [twmt_pkg::ENTRY_W-1:0] res_count_r;
  logic                        res_drop_r;

  logic [twmt_pkg::TIME_W:0]   limit;
  logic [twmt_pkg::ENTRY_W+twmt_pkg::COUNT_W-1:0] count_ext;

  // Ring index increments.
  assign head_inc = (head_r == twmt_pkg::ADDR_W'(twmt_pkg::DEPTH - 1)) ? '0
                  : head_r + twmt_pkg::ADDR_W'(1);
  assign tail_inc = (tail_r == twmt_pkg::ADDR_W'(twmt_pkg::DEPTH - 1)) ? '0
                  : tail_r + twmt_pkg::ADDR_W'(1);

  assign full = (count_r == twmt_pkg::COUNT_W'(twmt_pkg::DEPTH));
  assign push = cmd.add_phase && (cmd_r == twmt_pkg::CMD_ADD) && !full;

  // Expiry test in 33 bits so the sum cannot wrap.
  assign limit = {1'b0, rd_time_r} + {1'b0, window_r};

  assign st.empty         = (count_r == '0);
  assign st.add_hits_head = (cmd_r == twmt_pkg::CMD_ADD) && (count_r == '0);
  assign st.expired       = (count_r != '0) && (limit < {1'b0, now_r});

  // Queue, totals and drop flag update.
  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    totals_nxt = totals_r;
    drop_nxt   = drop_r;
    if (cmd.add_phase) begin
      drop_nxt = (cmd_r == twmt_pkg::CMD_ADD) && full;
    end
    if (push) begin
      tail_nxt  = tail_inc;
      count_nxt = count_r + twmt_pkg::COUNT_W'(1);
      for (int k = 0; k < twmt_pkg::NUM_METRICS; k++) begin
        totals_nxt[k] = totals_r[k]
                      + {{(twmt_pkg::TOTAL_W-twmt_pkg::METRIC_W){1'b0}}, metrics_r[k]};
      end
    end else if (cmd.retire) begin
      head_nxt  = head_inc;
      count_nxt = count_r - twmt_pkg::COUNT_W'(1);
      for (int k = 0; k < twmt_pkg::NUM_METRICS; k++) begin
        totals_nxt[k] = totals_r[k]
                      - {{(twmt_pkg::TOTAL_W-twmt_pkg::METRIC_W){1'b0}}, rd_metrics_r[k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= twmt_pkg::TIME_W'(1);
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      totals_r <= '0;
      drop_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        window_r <= cfg_wr_data;
      end
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      count_r  <= count_nxt;
      totals_r <= totals_nxt;
      drop_r   <= drop_nxt;
    end
  end

  // Input item capture on the accepting transfer.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r     <= in_cmd;
      stime_r   <= in_sample_time;
      now_r     <= in_now_time;
      metrics_r <= in_metrics;
    end
  end

  // Store: one write at the tail, one registered read at the head or the slot after it.
  assign rd_addr = cmd.rd_next ? head_inc : head_r;

  always_ff @(posedge clk) begin
    if (push) begin
      time_mem[tail_r]   <= stime_r;
      metric_mem[tail_r] <= metrics_r;
    end
    rd_time_r    <= time_mem[rd_addr];
    rd_metrics_r <= metric_mem[rd_addr];
  end

  // Result register, loaded once the expiry pass has finished.
  assign count_ext = {{twmt_pkg::ENTRY_W{1'b0}}, count_r};

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res_sums_r  <= totals_r;
      res_count_r <= count_ext[twmt_pkg::ENTRY_W-1:0];
      res_drop_r  <= drop_r;
    end
  end

  assign out_sums        = res_sums_r;
  assign out_entry_count = res_count_r;
  assign out_dropped     = res_drop_r;

endmodule
